// ===== design/pcpmb_pkg.sv =====
// shared types and constants for the per-core-pair message mailbox
package pcpmb_pkg;

  // fixed field widths of the stream words
  localparam int KIND_W    = 2;
  localparam int CORE_IN_W = 3;
  localparam int MSG_W     = 64;
  localparam int SEQ_W     = 32;
  localparam int PHASE_W   = 2;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 136;

  // request kinds carried on in_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_DRAIN = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_PHASE = 2'd3
  } kind_t;

  // target phase codes
  localparam logic [PHASE_W-1:0] PHASE_NONE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_DREAD,
    ST_DLOAD,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic dload;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic drain_go;
    logic last;
  } sts_t;

endpackage

// ===== design/per_core_pair_message_mailbox_core.sv =====
// Mailbox with one FIFO ring per (source, target) core pair.
// Push, query and phase write: the request passes lookup and execute, then the
// result is presented. Drain: each message passes a store read, a load and
// presentation, and the next one starts once the previous one is taken.
// One request at a time; the next word is taken the cycle after the last result.
// Sync reset clears the sequencer and the written marks of counters and phases.
module per_core_pair_message_mailbox_core
  import pcpmb_pkg::*;
#(
  parameter int CORES        = 8,
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // from_core[2:0], to_core[5:3], payload[69:6], call_number[101:70],
  // phase_value[103:102]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accepted[0], sequence_res[32:1], message[96:33], collected[97],
  // need_interrupt[98], ring_empty[99], head_count[131:100], zero[135:132]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // message_valid[0]
  output logic [0:0]             out_tuser,
  output logic                   out_tlast
);

  cmd_t             cmd;
  sts_t             sts;
  logic             accepted;
  logic [SEQ_W-1:0] sequence_res;
  logic [MSG_W-1:0] message;
  logic             message_valid;
  logic             collected;
  logic             need_interrupt;
  logic             ring_empty;
  logic [SEQ_W-1:0] head_count;

  // sequencer
  pcpmb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath
  pcpmb_dpath #(
    .CORES        (CORES),
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_tuser),
    .in_from_core       (in_tdata[2:0]),
    .in_to_core         (in_tdata[5:3]),
    .in_payload         (in_tdata[69:6]),
    .in_call_number     (in_tdata[101:70]),
    .in_phase_value     (in_tdata[103:102]),
    .out_accepted       (accepted),
    .out_sequence_res   (sequence_res),
    .out_message        (message),
    .out_message_valid  (message_valid),
    .out_last           (out_tlast),
    .out_collected      (collected),
    .out_need_interrupt (need_interrupt),
    .out_ring_empty     (ring_empty),
    .out_head_count     (head_count)
  );

  // result word packing
  assign out_tdata = {4'b0000, head_count, ring_empty, need_interrupt, collected,
                      message, sequence_res, accepted};
  assign out_tuser = message_valid;

endmodule

// ===== design/pcpmb_ctrl.sv =====
// sequencer for the mailbox: handshakes and step ordering
module pcpmb_ctrl
  import pcpmb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = sts.drain_go ? ST_DREAD : ST_OUT;
      end
      ST_DREAD: state_nxt = ST_DLOAD;
      ST_DLOAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) state_nxt = sts.last ? ST_IDLE : ST_DREAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    out_tvalid  = (state_r == ST_OUT);
    cmd.capture = (state_r == ST_IDLE) && in_tvalid;
    cmd.exec    = (state_r == ST_EXEC);
    cmd.dload   = (state_r == ST_DLOAD);
  end

endmodule

// ===== design/pcpmb_dpath.sv =====
// mailbox datapath: ring store, counter and phase memories, result registers
module pcpmb_dpath
  import pcpmb_pkg::*;
#(
  parameter int CORES        = 8,
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [CORE_IN_W-1:0] in_from_core,
  input  logic [CORE_IN_W-1:0] in_to_core,
  input  logic [MSG_W-1:0]     in_payload,
  input  logic [SEQ_W-1:0]     in_call_number,
  input  logic [PHASE_W-1:0]   in_phase_value,
  output logic                 out_accepted,
  output logic [SEQ_W-1:0]     out_sequence_res,
  output logic [MSG_W-1:0]     out_message,
  output logic                 out_message_valid,
  output logic                 out_last,
  output logic                 out_collected,
  output logic                 out_need_interrupt,
  output logic                 out_ring_empty,
  output logic [SEQ_W-1:0]     out_head_count
);

  localparam int RINGS  = CORES * CORES;
  localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int RING_W = $clog2(RINGS);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ST_AW  = $clog2(RINGS * DEPTH);
  localparam int CE_W   = 2 * SEQ_W + 2 * SLOT_W;

  // core index reduced into range by repeated subtraction (index is narrow)
  function automatic logic [CORE_W-1:0] core_reduce(input logic [CORE_IN_W-1:0] idx);
    logic [6:0] v;
    v = 7'(idx);
    for (int i = 0; i < 4; i++) begin
      if (v >= 7'(CORES)) v = v - 7'(CORES);
    end
    return CORE_W'(v);
  endfunction

  // ring slot step with wrap at depth
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  kind_t                     kind_r;
  logic [CORE_W-1:0]         tgt_r;
  logic [RING_W-1:0]         ring_r;
  logic [PAYLOAD_BITS-1:0]   payload_r;
  logic [SEQ_W-1:0]          call_r;
  logic [PHASE_W-1:0]        phase_r;
  logic [CORE_W-1:0]         src_red;
  logic [CORE_W-1:0]         tgt_red;

  logic [CE_W-1:0]           cnt_mem [RINGS];
  logic [RINGS-1:0]          cnt_vld_r;
  logic [CE_W-1:0]           cnt_rd_r;
  logic                      cnt_vld_rd_r;
  logic [PHASE_W-1:0]        ph_mem [CORES];
  logic [CORES-1:0]          ph_vld_r;
  logic [PHASE_W-1:0]        ph_rd_r;
  logic                      ph_vld_rd_r;
  logic [PAYLOAD_BITS-1:0]   st_mem [RINGS * DEPTH];
  logic [PAYLOAD_BITS-1:0]   st_rd_r;

  logic [CE_W-1:0]           cur;
  logic [SEQ_W-1:0]          head;
  logic [SEQ_W-1:0]          tail;
  logic [SLOT_W-1:0]         hslot;
  logic [SLOT_W-1:0]         tslot;
  logic [PHASE_W-1:0]        cur_phase;
  logic [SEQ_W-1:0]          used;
  logic                      full;
  logic                      push_ok;
  logic [CNT_W-1:0]          drain_n;
  logic [SEQ_W-1:0]          head_nxt;
  logic [SEQ_W-1:0]          tail_nxt;
  logic                      cnt_we;
  logic [CE_W-1:0]           cnt_wdata;
  logic                      st_we;
  logic [ST_AW-1:0]          st_wr_addr;
  logic [ST_AW-1:0]          st_rd_addr;
  logic                      ph_we;

  logic [CNT_W-1:0]          dcnt_r;
  logic [SLOT_W-1:0]         rptr_r;

  logic                      acc_r;
  logic [SEQ_W-1:0]          seq_r;
  logic [MSG_W-1:0]          msg_r;
  logic                      mv_r;
  logic                      last_r;
  logic                      coll_r;
  logic                      need_int_r;
  logic                      empty_r;
  logic [SEQ_W-1:0]          head_cnt_r;

  assign src_red = core_reduce(in_from_core);
  assign tgt_red = core_reduce(in_to_core);

  // capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= kind_t'(in_kind);
      tgt_r     <= tgt_red;
      ring_r    <= RING_W'(tgt_red) * RING_W'(CORES) + RING_W'(src_red);
      payload_r <= in_payload[PAYLOAD_BITS-1:0];
      call_r    <= in_call_number;
      phase_r   <= in_phase_value;
    end
  end

  // current ring and phase state, unwritten entries read as zero
  always_comb begin
    cur       = cnt_vld_rd_r ? cnt_rd_r : '0;
    head      = cur[CE_W-1 -: SEQ_W];
    tail      = cur[CE_W-SEQ_W-1 -: SEQ_W];
    hslot     = cur[2*SLOT_W-1 -: SLOT_W];
    tslot     = cur[SLOT_W-1:0];
    cur_phase = ph_vld_rd_r ? ph_rd_r : PHASE_NONE;
  end

  // step decisions
  always_comb begin
    used     = tail - head;
    full     = (used >= SEQ_W'(DEPTH));
    push_ok  = (kind_r == KIND_PUSH) && !full;
    drain_n  = (used > SEQ_W'(DEPTH)) ? CNT_W'(DEPTH) : used[CNT_W-1:0];
    sts.drain_go = (kind_r == KIND_DRAIN) && (used != '0);
    sts.last     = last_r;
    head_nxt = sts.drain_go ? head + SEQ_W'(drain_n) : head;
    tail_nxt = push_ok ? tail + SEQ_W'(1) : tail;
    cnt_we   = cmd.exec && (push_ok || sts.drain_go);
    if (push_ok) begin
      cnt_wdata = {head, tail_nxt, hslot, slot_inc(tslot)};
    end else begin
      cnt_wdata = {head_nxt, tail, tslot, tslot};
    end
    st_we      = cmd.exec && push_ok;
    st_wr_addr = ST_AW'(ring_r) * ST_AW'(DEPTH) + ST_AW'(tslot);
    st_rd_addr = ST_AW'(ring_r) * ST_AW'(DEPTH) + ST_AW'(rptr_r);
    ph_we      = cmd.exec && (kind_r == KIND_PHASE);
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[ring_r] <= cnt_wdata;
    cnt_rd_r <= cnt_mem[ring_r];
  end

  // phase memory
  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[tgt_r] <= phase_r;
    ph_rd_r <= ph_mem[tgt_r];
  end

  // ring store
  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wr_addr] <= payload_r;
    st_rd_r <= st_mem[st_rd_addr];
  end

  // written marks for counters and phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r    <= '0;
      ph_vld_r     <= '0;
      cnt_vld_rd_r <= 1'b0;
      ph_vld_rd_r  <= 1'b0;
    end else begin
      if (cnt_we) cnt_vld_r[ring_r] <= 1'b1;
      if (ph_we) ph_vld_r[tgt_r] <= 1'b1;
      cnt_vld_rd_r <= cnt_vld_r[ring_r];
      ph_vld_rd_r  <= ph_vld_r[tgt_r];
    end
  end

  // drain walk and result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r      <= push_ok;
      seq_r      <= push_ok ? tail : '0;
      msg_r      <= '0;
      mv_r       <= 1'b0;
      last_r     <= 1'b1;
      coll_r     <= (kind_r == KIND_QUERY) && (head > call_r);
      need_int_r <= ((kind_r == KIND_PHASE) ? phase_r : cur_phase) != PHASE_FIRST;
      empty_r    <= (head_nxt == tail_nxt);
      head_cnt_r <= head_nxt;
      dcnt_r     <= drain_n;
      rptr_r     <= hslot;
    end else if (cmd.dload) begin
      msg_r  <= MSG_W'(st_rd_r);
      mv_r   <= 1'b1;
      last_r <= (dcnt_r == CNT_W'(1));
      dcnt_r <= dcnt_r - CNT_W'(1);
      rptr_r <= slot_inc(rptr_r);
    end
  end

  assign out_accepted       = acc_r;
  assign out_sequence_res   = seq_r;
  assign out_message        = msg_r;
  assign out_message_valid  = mv_r;
  assign out_last           = last_r;
  assign out_collected      = coll_r;
  assign out_need_interrupt = need_int_r;
  assign out_ring_empty     = empty_r;
  assign out_head_count     = head_cnt_r;

endmodule
